// File: src/type_length_frame_deframer_unit_macros.svh
// assertion macros shared by the deframer rtl
`ifndef TYPE_LENGTH_FRAME_DEFRAMER_UNIT_MACROS_SVH
`define TYPE_LENGTH_FRAME_DEFRAMER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define TLFD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deframer check failed");
// next-cycle implication
`define TLFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deframer check failed");
`else
`define TLFD_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define TLFD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: src/tlfd_pkg.sv
// shared types, constants and helpers of the frame deframer
package tlfd_pkg;

    localparam int CFG_DATA_W = 31;

    typedef logic [CFG_DATA_W-1:0] t_cfg_data;

    typedef enum logic [0:0] {
        CFG_BIG_ENDIAN = 1'b0,
        CFG_MAX_LEN    = 1'b1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_HEADER  = 3'd0,
        ST_PAYLOAD = 3'd1,
        ST_EMPTY   = 3'd2,
        ST_BADLEN  = 3'd3
    } t_status;

    localparam logic [31:0]           HEADER_BYTES   = 32'd8;
    localparam logic [1:0]            LAST_FIELD_POS = 2'd3;
    localparam logic [31:0]           TYPE_RESET     = 32'hFFFF_FFFF;
    localparam logic [CFG_DATA_W-1:0] MAX_LEN_RESET  = 31'd65536;

    typedef struct packed {
        logic                  big_endian;
        logic [CFG_DATA_W-1:0] max_frame_length;
    } t_cfg;

    typedef struct packed {
        t_status            status;
        logic [7:0]         out_byte;
        logic signed [31:0] message_type;
        logic [30:0]        payload_index;
        logic               last_byte;
    } t_result;

    // place one header byte into a 32-bit field
    function automatic logic [31:0] put_byte(input logic [31:0] field,
                                             input logic [1:0]  pos,
                                             input logic [7:0]  b,
                                             input logic        big_endian);
        logic [31:0] res;
        if (big_endian) begin
            res = {field[23:0], b};
        end else begin
            case (pos)
                2'd0:    res = {field[31:8], b};
                2'd1:    res = {field[31:16], b, field[7:0]};
                2'd2:    res = {field[31:24], b, field[15:0]};
                default: res = {b, field[23:0]};
            endcase
        end
        return res;
    endfunction

endpackage

// File: src/tlfd_byte_if.sv
// byte input channel
interface tlfd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

// File: src/tlfd_result_if.sv
// result channel, one beat per input byte
interface tlfd_result_if;
    logic                 valid;
    logic                 ready;
    tlfd_pkg::t_status    status;
    logic [7:0]           out_byte;
    logic signed [31:0]   message_type;
    logic [30:0]          payload_index;
    logic                 last_byte;

    modport source (output valid, output status, output out_byte, output message_type,
                    output payload_index, output last_byte, input ready);
    modport sink   (input valid, input status, input out_byte, input message_type,
                    input payload_index, input last_byte, output ready);
endinterface

// File: src/tlfd_cfg_regs.sv
// configuration registers of the deframer
module tlfd_cfg_regs (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_we,
    input  tlfd_pkg::t_cfg_idx   i_idx,
    input  tlfd_pkg::t_cfg_data  i_data,
    output tlfd_pkg::t_cfg       o_cfg
);

    logic                        r_big_endian;
    logic [tlfd_pkg::CFG_DATA_W-1:0] r_max_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_big_endian <= 1'b0;
            r_max_len    <= tlfd_pkg::MAX_LEN_RESET;
        end else if (i_we) begin
            case (i_idx)
                tlfd_pkg::CFG_BIG_ENDIAN: r_big_endian <= i_data[0];
                tlfd_pkg::CFG_MAX_LEN:    r_max_len    <= i_data;
                default:                  r_big_endian <= r_big_endian;
            endcase
        end
    end

    assign o_cfg.big_endian       = r_big_endian;
    assign o_cfg.max_frame_length = r_max_len;

endmodule

// File: src/tlfd_step.sv
// frame state and per-byte result logic
`include "type_length_frame_deframer_unit_macros.svh"
module tlfd_step (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic [7:0]        i_byte,
    input  tlfd_pkg::t_cfg    i_cfg,
    output tlfd_pkg::t_result o_res
);

    typedef enum logic [1:0] {
        PH_TYPE    = 2'd0,
        PH_LENGTH  = 2'd1,
        PH_PAYLOAD = 2'd2
    } t_phase;

    t_phase      r_phase,  n_phase;
    logic [1:0]  r_hcount, n_hcount;
    logic [31:0] r_type,   n_type;
    logic [31:0] r_length, n_length;
    logic [30:0] r_pcount, n_pcount;

    logic [31:0] w_field;
    logic [31:0] w_plen;
    logic [30:0] w_cnt_inc;
    tlfd_pkg::t_result w_res;

    always_comb begin
        w_cnt_inc = r_pcount + 31'd1;
        w_plen    = r_length - tlfd_pkg::HEADER_BYTES;
        w_field   = tlfd_pkg::put_byte((r_phase == PH_LENGTH) ? r_length : r_type,
                                       r_hcount, i_byte, i_cfg.big_endian);

        n_phase  = r_phase;
        n_hcount = r_hcount;
        n_type   = r_type;
        n_length = r_length;
        n_pcount = r_pcount;

        w_res.status        = tlfd_pkg::ST_HEADER;
        w_res.out_byte      = 8'd0;
        w_res.message_type  = r_type;
        w_res.payload_index = 31'd0;
        w_res.last_byte     = 1'b0;

        case (r_phase)
            PH_PAYLOAD: begin
                w_res.status        = tlfd_pkg::ST_PAYLOAD;
                w_res.out_byte      = i_byte;
                w_res.payload_index = r_pcount;
                n_pcount            = w_cnt_inc;
                if ({1'b0, w_cnt_inc} >= w_plen) begin
                    w_res.last_byte = 1'b1;
                    n_phase  = PH_TYPE;
                    n_hcount = 2'd0;
                    n_type   = tlfd_pkg::TYPE_RESET;
                    n_length = 32'd0;
                    n_pcount = 31'd0;
                end
            end
            PH_LENGTH: begin
                n_length = w_field;
                n_hcount = r_hcount + 2'd1;
                if (r_hcount == tlfd_pkg::LAST_FIELD_POS) begin
                    if (w_field < tlfd_pkg::HEADER_BYTES ||
                        w_field > {1'b0, i_cfg.max_frame_length}) begin
                        w_res.status = tlfd_pkg::ST_BADLEN;
                        n_phase  = PH_TYPE;
                        n_type   = tlfd_pkg::TYPE_RESET;
                        n_length = 32'd0;
                        n_pcount = 31'd0;
                    end else if (w_field == tlfd_pkg::HEADER_BYTES) begin
                        w_res.status    = tlfd_pkg::ST_EMPTY;
                        w_res.last_byte = 1'b1;
                        n_phase  = PH_TYPE;
                        n_type   = tlfd_pkg::TYPE_RESET;
                        n_length = 32'd0;
                        n_pcount = 31'd0;
                    end else begin
                        n_phase  = PH_PAYLOAD;
                        n_pcount = 31'd0;
                    end
                end
            end
            default: begin
                // type field; the unused phase code lands here too
                n_type             = w_field;
                w_res.message_type = w_field;
                n_hcount           = r_hcount + 2'd1;
                if (r_hcount == tlfd_pkg::LAST_FIELD_POS) begin
                    n_phase  = PH_LENGTH;
                    n_length = 32'd0;
                end else begin
                    n_phase  = PH_TYPE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_TYPE;
            r_hcount <= 2'd0;
            r_type   <= tlfd_pkg::TYPE_RESET;
            r_length <= 32'd0;
            r_pcount <= 31'd0;
        end else if (i_en) begin
            r_phase  <= n_phase;
            r_hcount <= n_hcount;
            r_type   <= n_type;
            r_length <= n_length;
            r_pcount <= n_pcount;
        end
    end

    assign o_res = w_res;

    `TLFD_ASSERT_NOW(a_payload_len, i_clk, i_rst_n,
        r_phase == PH_PAYLOAD, r_length > tlfd_pkg::HEADER_BYTES)
    `TLFD_ASSERT_NEXT(a_frame_restart, i_clk, i_rst_n, i_en && w_res.last_byte,
        r_phase == PH_TYPE && r_type == tlfd_pkg::TYPE_RESET && r_pcount == 31'd0)

endmodule

// File: src/type_length_frame_deframer_unit.sv
// top level: input beat register, frame step logic, result register
// a byte passes the input beat register, then its result is held in the result register
// throughput: one byte per cycle while results are taken; the frame state updates once per byte
// a stalled result beat holds both registers, input ready drops when both are full and stalled
// reset (synchronous, active low): channels empty, little endian, max length 65536,
// deframer waiting for the first byte of a type field
`include "type_length_frame_deframer_unit_macros.svh"
module type_length_frame_deframer_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  tlfd_pkg::t_cfg_idx   i_cfg_idx,
    input  tlfd_pkg::t_cfg_data  i_cfg_data,
    tlfd_byte_if.sink            i_in,
    tlfd_result_if.source        o_res
);

    tlfd_pkg::t_cfg    w_cfg;
    tlfd_pkg::t_result w_step_res;

    // input beat register
    logic       r_in_valid;
    logic [7:0] r_in_byte;

    // result register
    logic              r_out_valid;
    tlfd_pkg::t_result r_res;

    logic w_advance;
    logic w_step_en;

    // result register frees up when empty or when its beat is taken
    assign w_advance = !r_out_valid || o_res.ready;
    // byte moves into the step logic and its result is captured together
    assign w_step_en = r_in_valid && w_advance;
    assign i_in.ready = !r_in_valid || w_advance;

    tlfd_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_idx   (i_cfg_idx),
        .i_data  (i_cfg_data),
        .o_cfg   (w_cfg)
    );

    tlfd_step u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_step_en),
        .i_byte  (r_in_byte),
        .i_cfg   (w_cfg),
        .o_res   (w_step_res)
    );

    // input register: control reset, payload loaded on an accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.data_byte;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step_en) begin
            r_res <= w_step_res;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.status        = r_res.status;
    assign o_res.out_byte      = r_res.out_byte;
    assign o_res.message_type  = r_res.message_type;
    assign o_res.payload_index = r_res.payload_index;
    assign o_res.last_byte     = r_res.last_byte;

    `TLFD_ASSERT_NOW(a_last_kind, i_clk, i_rst_n, r_out_valid && r_res.last_byte,
        r_res.status == tlfd_pkg::ST_PAYLOAD || r_res.status == tlfd_pkg::ST_EMPTY)
    `TLFD_ASSERT_NOW(a_badlen_clean, i_clk, i_rst_n,
        r_out_valid && r_res.status == tlfd_pkg::ST_BADLEN,
        !r_res.last_byte && r_res.out_byte == 8'd0 && r_res.payload_index == 31'd0)
    `TLFD_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, r_in_valid && !w_advance,
        r_in_valid && $stable(r_in_byte))

endmodule

// File: sim/tlfd_checker.sv
`timescale 1ns / 1ps
// watches the byte and result channels, predicts every result beat and compares
module tlfd_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  tlfd_pkg::t_cfg_idx  i_cfg_idx,
    input  tlfd_pkg::t_cfg_data i_cfg_data,
    tlfd_byte_if                i_in,
    tlfd_result_if              i_res,
    output int                  o_fail_count,
    output int                  o_outstanding
);
    import tlfd_pkg::*;

    localparam int REPORT_LIMIT = 10;

    typedef enum logic [1:0] {
        FR_TYPE    = 2'd0,
        FR_LENGTH  = 2'd1,
        FR_PAYLOAD = 2'd2
    } t_frame_phase;

    logic         cfg_big;
    logic [30:0]  cfg_max;

    t_frame_phase fr_phase;
    logic [1:0]   field_pos;
    logic [31:0]  type_acc;
    logic [31:0]  length_acc;
    logic [30:0]  payload_cnt;

    t_result      predicted_beats[$];
    int           fail_count = 0;

    initial begin
        o_fail_count  = 0;
        o_outstanding = 0;
    end

    // header byte goes to its slot (little endian) or shifts in at the low end
    function automatic logic [31:0] insert_byte(input logic [31:0] field,
                                                input logic [1:0]  pos,
                                                input logic [7:0]  value);
        if (cfg_big) begin
            return {field[23:0], value};
        end
        field[pos*8 +: 8] = value;
        return field;
    endfunction

    function automatic void restart_frame();
        fr_phase    = FR_TYPE;
        field_pos   = 2'd0;
        type_acc    = TYPE_RESET;
        length_acc  = '0;
        payload_cnt = '0;
    endfunction

    function automatic t_result deframe_byte(input logic [7:0] value);
        t_result     r;
        logic [31:0] payload_len;
        r.status        = ST_HEADER;
        r.out_byte      = '0;
        r.message_type  = '0;
        r.payload_index = '0;
        r.last_byte     = 1'b0;
        case (fr_phase)
            FR_PAYLOAD: begin
                payload_len     = length_acc - HEADER_BYTES;
                r.status        = ST_PAYLOAD;
                r.out_byte      = value;
                r.message_type  = type_acc;
                r.payload_index = payload_cnt;
                payload_cnt     = payload_cnt + 31'd1;
                if ({1'b0, payload_cnt} >= payload_len) begin
                    r.last_byte = 1'b1;
                    restart_frame();
                end
            end
            FR_LENGTH: begin
                length_acc     = insert_byte(length_acc, field_pos, value);
                field_pos      = field_pos + 2'd1;
                r.message_type = type_acc;
                if (field_pos == 2'd0) begin
                    if (length_acc < HEADER_BYTES || length_acc > {1'b0, cfg_max}) begin
                        r.status = ST_BADLEN;
                        restart_frame();
                    end else if (length_acc == HEADER_BYTES) begin
                        r.status    = ST_EMPTY;
                        r.last_byte = 1'b1;
                        restart_frame();
                    end else begin
                        fr_phase    = FR_PAYLOAD;
                        payload_cnt = '0;
                    end
                end
            end
            default: begin
                type_acc       = insert_byte(type_acc, field_pos, value);
                field_pos      = field_pos + 2'd1;
                r.message_type = type_acc;
                if (field_pos == 2'd0) begin
                    fr_phase   = FR_LENGTH;
                    length_acc = '0;
                end
            end
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            cfg_big = 1'b0;
            cfg_max = MAX_LEN_RESET;
            restart_frame();
            predicted_beats.delete();
        end else begin
            if (i_res.valid && i_res.ready) begin
                got.status        = i_res.status;
                got.out_byte      = i_res.out_byte;
                got.message_type  = i_res.message_type;
                got.payload_index = i_res.payload_index;
                got.last_byte     = i_res.last_byte;
                if (predicted_beats.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("%0t: result beat with nothing pending: status %0d byte %02h",
                                 $realtime, got.status, got.out_byte);
                end else begin
                    want = predicted_beats.pop_front();
                    if (got.status !== want.status || got.out_byte !== want.out_byte ||
                        got.message_type !== want.message_type ||
                        got.payload_index !== want.payload_index ||
                        got.last_byte !== want.last_byte) begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT) begin
                            $display("%0t: mismatch, want status %0d byte %02h type %08h idx %0d last %0b",
                                     $realtime, want.status, want.out_byte, want.message_type,
                                     want.payload_index, want.last_byte);
                            $display("%0t:            got status %0d byte %02h type %08h idx %0d last %0b",
                                     $realtime, got.status, got.out_byte, got.message_type,
                                     got.payload_index, got.last_byte);
                        end
                    end
                end
            end
            if (i_in.valid && i_in.ready)
                predicted_beats.push_back(deframe_byte(i_in.data_byte));
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_BIG_ENDIAN: cfg_big = i_cfg_data[0];
                    CFG_MAX_LEN:    cfg_max = i_cfg_data;
                    default: ;
                endcase
            end
        end
        o_outstanding <= predicted_beats.size();
        o_fail_count  <= fail_count;
    end

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
// testbench top: byte stimulus, result sink, register writes, watchdog and verdict
module tb;
    import tlfd_pkg::*;

    localparam int HOLD_CYCLES       = 150;   // long receiver hold-off
    localparam int QUIET_LIMIT       = 2000;  // cycles with no beat before giving up
    localparam int TAIL_CYCLES       = 4;     // margin before the verdict
    localparam int PHASE_BYTES       = 140;   // random bytes per setting
    localparam int NUM_PHASES        = 6;
    localparam int PAYLOAD_CAP       = 32;    // legal frames stay short

    // one setting per random phase, extremes of the maximum length included
    localparam logic [30:0] PHASE_MAX [NUM_PHASES] = '{
        31'h7FFF_FFFF, 31'd8, 31'd0, 31'd20, 31'd65536, 31'd1000
    };
    localparam logic [NUM_PHASES-1:0] PHASE_BIG = 6'b010101;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        cfg_we;
    t_cfg_idx    cfg_idx;
    t_cfg_data   cfg_data;

    tlfd_byte_if   byte_ch ();
    tlfd_result_if result_ch ();

    int          fail_count;
    int          outstanding;

    // shared knobs between the stimulus and the result sink
    logic        idle_on  = 1'b1;
    logic        hold_req = 1'b0;
    // the stimulus side's own copy of the settings, used to encode lengths
    logic        cur_big;
    logic [30:0] cur_max;
    int          bytes_sent   = 0;
    int          quiet_cycles = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    type_length_frame_deframer_unit DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (byte_ch),
        .o_res      (result_ch)
    );

    tlfd_checker u_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .i_in          (byte_ch),
        .i_res         (result_ch),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    // offer one byte, after a random gap while idling is on; return once the beat is taken
    task automatic send_byte(input logic [7:0] value);
        int gap;
        gap = idle_on ? $urandom_range(0, 3) : 0;
        if (gap != 0) begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        byte_ch.valid     <= 1'b1;
        byte_ch.data_byte <= value;
        do @(posedge i_clk); while (!byte_ch.ready);
        bytes_sent++;
    endtask

    // length field in the byte order currently set in the block
    task automatic send_length(input logic [31:0] len);
        for (int k = 0; k < 4; k++)
            send_byte(cur_big ? len[31-8*k -: 8] : len[8*k +: 8]);
    endtask

    // full frame; payload only goes out when the block will accept the length
    task automatic send_frame(input logic [31:0] msg_type, input logic [31:0] len);
        for (int k = 0; k < 4; k++)
            send_byte(msg_type[8*k +: 8]);
        send_length(len);
        if (len > HEADER_BYTES && len <= {1'b0, cur_max}) begin
            for (int k = 0; k < int'(len) - 8; k++)
                send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    // mostly legal lengths, the rest short, empty, over the limit or negative
    function automatic logic [31:0] pick_length();
        int          roll;
        logic [31:0] cap;
        roll = $urandom_range(0, 99);
        cap  = ({1'b0, cur_max} < 32'(8 + PAYLOAD_CAP)) ? {1'b0, cur_max}
                                                          : 32'(8 + PAYLOAD_CAP);
        if (roll < 60 && cap > HEADER_BYTES)
            return 32'd9 + $urandom_range(0, cap - 32'd9);
        if (roll < 70)
            return HEADER_BYTES;
        if (roll < 80)
            return $urandom_range(0, 7);
        if (roll < 90)
            return {1'b0, cur_max} + 32'd1 + $urandom_range(0, 1000);
        return {1'b1, 31'($urandom)};
    endfunction

    // sender stops and waits until every predicted beat has come back
    task automatic wait_results_done();
        byte_ch.valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
    endtask

    // both registers, back to back, only while the block is idle
    task automatic set_config(input logic big, input logic [30:0] max_len);
        cur_big  = big;
        cur_max  = max_len;
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_BIG_ENDIAN;
        cfg_data <= t_cfg_data'(big);
        @(posedge i_clk);
        cfg_idx  <= CFG_MAX_LEN;
        cfg_data <= max_len;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
    endtask

    // result sink: random stall per beat while idling is on, one long hold-off on request
    initial begin : result_sink
        int stall;
        result_ch.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (hold_req) begin
                result_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end
            stall = idle_on ? $urandom_range(0, 3) : 0;
            if (stall != 0) begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            result_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!result_ch.valid);
        end
    end

    // watchdog: too long without any beat or register write
    always @(posedge i_clk) begin
        if (!i_rst_n || (byte_ch.valid && byte_ch.ready) ||
            (result_ch.valid && result_ch.ready) || cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        int start;
        byte_ch.valid     <= 1'b0;
        byte_ch.data_byte <= '0;
        cfg_we            <= 1'b0;
        cfg_idx           <= CFG_BIG_ENDIAN;
        cfg_data          <= '0;
        i_rst_n           <= 1'b0;
        cur_big           = 1'b0;
        cur_max           = MAX_LEN_RESET;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: one-byte payload with all-zero and all-one type bytes
        send_frame(32'h807F_FF00, 32'd9);
        // empty frame, done on the last length byte
        send_frame(32'h4433_2211, HEADER_BYTES);
        // byte order flipped in the middle of the type field, then a short length
        send_byte(8'h55);
        send_byte(8'h66);
        wait_results_done();
        set_config(1'b1, cur_max);
        send_byte(8'h77);
        send_byte(8'h88);
        send_length(32'd3);

        // random frames under each setting; idling off in every third phase
        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_results_done();
            set_config(PHASE_BIG[p], PHASE_MAX[p]);
            idle_on = (p % 3) != 2;
            // receiver holds off while the sender keeps pushing, block fills up
            if (p == 2)
                hold_req = 1'b1;
            start = bytes_sent;
            while (bytes_sent - start < PHASE_BYTES)
                send_frame($urandom, pick_length());
        end

        wait_results_done();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && outstanding == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
